[rtl/slt_pkg.sv]
`default_nettype none
package slt_pkg;

   localparam int MaxTokenChars = 64;
   localparam int LineChars = 4096;

   typedef enum logic [3:0] {
      ST_START = 4'd0,
      ST_ID    = 4'd1,
      ST_LNUM  = 4'd2,
      ST_DNUM  = 4'd3,
      ST_VAR   = 4'd4,
      ST_AMP   = 4'd5,
      ST_OP    = 4'd6,
      ST_STR   = 4'd7,
      ST_LCOM  = 4'd8,
      ST_BCOM  = 4'd9,
      ST_BSTAR = 4'd10
   } scan_state_type;

   localparam logic [3:0] ERR_NONE = 4'd0;
   localparam logic [3:0] ERR_CHAR = 4'd1;
   localparam logic [3:0] ERR_BANG = 4'd2;
   localparam logic [3:0] ERR_BAR = 4'd3;
   localparam logic [3:0] ERR_AMP = 4'd4;
   localparam logic [3:0] ERR_BCOM = 4'd5;
   localparam logic [3:0] ERR_STR = 4'd6;
   localparam logic [3:0] ERR_LONG = 4'd7;
   localparam logic [3:0] ERR_WORD = 4'd8;

   localparam logic [5:0] TK_EOF = 6'd0;
   localparam logic [5:0] TK_VAR = 6'd11;
   localparam logic [5:0] TK_INT = 6'd12;
   localparam logic [5:0] TK_DEC = 6'd13;
   localparam logic [5:0] TK_STR = 6'd14;
   localparam logic [5:0] TK_ANDAND = 6'd15;
   localparam logic [5:0] TK_EQEQ = 6'd16;
   localparam logic [5:0] TK_EQ = 6'd17;
   localparam logic [5:0] TK_LE = 6'd18;
   localparam logic [5:0] TK_LT = 6'd19;
   localparam logic [5:0] TK_GE = 6'd20;
   localparam logic [5:0] TK_GT = 6'd21;
   localparam logic [5:0] TK_NE = 6'd22;
   localparam logic [5:0] TK_INC = 6'd23;
   localparam logic [5:0] TK_PLUS = 6'd24;
   localparam logic [5:0] TK_DECR = 6'd25;
   localparam logic [5:0] TK_MINUS = 6'd26;
   localparam logic [5:0] TK_OROR = 6'd27;
   localparam logic [5:0] TK_STAR = 6'd28;
   localparam logic [5:0] TK_SLASH = 6'd29;
   localparam logic [5:0] TK_LPAR = 6'd30;
   localparam logic [5:0] TK_RPAR = 6'd31;
   localparam logic [5:0] TK_LBRACE = 6'd32;
   localparam logic [5:0] TK_RBRACE = 6'd33;
   localparam logic [5:0] TK_SEMI = 6'd34;
   localparam logic [5:0] TK_COMMA = 6'd35;
   localparam logic [5:0] TK_DOT = 6'd36;

   typedef struct packed {
      logic [5:0] kind;
      logic [3:0] err;
      logic [6:0] len;
   } token_type;

   function automatic token_type mk(input logic [5:0] k, input logic [3:0] e,
                                    input logic [6:0] l);
      token_type t;
      t.kind = k;
      t.err = e;
      t.len = l;
      return t;
   endfunction

   function automatic token_type keyword(input logic [6:0] len, input logic [31:0] w);
      token_type t;
      t = mk(TK_EOF, ERR_WORD, 7'd0);
      case (len)
         7'd2: if (w[15:0] == "if" && w[31:16] == 16'd0) t = mk(6'd2, ERR_NONE, len);
         7'd3: begin
            if (w == {8'd0, "for"}) t = mk(6'd5, ERR_NONE, len);
            if (w == {8'd0, "int"}) t = mk(6'd8, ERR_NONE, len);
            if (w == {8'd0, "dec"}) t = mk(6'd10, ERR_NONE, len);
         end
         7'd4: begin
            if (w == "main") t = mk(6'd1, ERR_NONE, len);
            if (w == "then") t = mk(6'd3, ERR_NONE, len);
            if (w == "else") t = mk(6'd4, ERR_NONE, len);
            if (w == "gets") t = mk(6'd6, ERR_NONE, len);
            if (w == "puts") t = mk(6'd7, ERR_NONE, len);
            if (w == "char") t = mk(6'd9, ERR_NONE, len);
         end
         default: t = mk(TK_EOF, ERR_WORD, 7'd0);
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

[rtl/slt_scan.sv]
`default_nettype none
module slt_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [7:0]                  char_code,
   input  wire logic                        end_of_input,
   output slt_pkg::token_type               tok0,
   output slt_pkg::token_type               tok1,
   output logic [1:0]                       count,
   output logic [15:0]                      line0_out,
   output logic [11:0]                      col0_out,
   output logic [15:0]                      line_out,
   output logic [11:0]                      col_out
);

   slt_pkg::scan_state_type state_ff, state_in;
   logic [7:0]  pend_ff, pend_in, prev_ff, prev_in;
   logic [6:0]  lex_ff, lex_in;
   logic [31:0] word_ff, word_in;
   logic [15:0] line_ff, line_in;
   logic [11:0] col_ff, col_in;

   function automatic logic is_lower(input logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction
   function automatic logic is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction
   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic slt_pkg::token_type single_op(input logic [7:0] p);
      case (p)
         "=": return slt_pkg::mk(slt_pkg::TK_EQ, slt_pkg::ERR_NONE, 7'd1);
         "<": return slt_pkg::mk(slt_pkg::TK_LT, slt_pkg::ERR_NONE, 7'd1);
         ">": return slt_pkg::mk(slt_pkg::TK_GT, slt_pkg::ERR_NONE, 7'd1);
         "+": return slt_pkg::mk(slt_pkg::TK_PLUS, slt_pkg::ERR_NONE, 7'd1);
         "-": return slt_pkg::mk(slt_pkg::TK_MINUS, slt_pkg::ERR_NONE, 7'd1);
         "/": return slt_pkg::mk(slt_pkg::TK_SLASH, slt_pkg::ERR_NONE, 7'd1);
         "!": return slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_BANG, 7'd0);
         default: return slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_BAR, 7'd0);
      endcase
   endfunction

   function automatic logic [5:0] double_kind(input logic [7:0] p, input logic [7:0] c);
      logic [5:0] k;
      k = slt_pkg::TK_EOF;
      if (c == "=") begin
         if (p == "=") k = slt_pkg::TK_EQEQ;
         if (p == "<") k = slt_pkg::TK_LE;
         if (p == ">") k = slt_pkg::TK_GE;
         if (p == "!") k = slt_pkg::TK_NE;
      end
      if (p == "+" && c == "+") k = slt_pkg::TK_INC;
      if (p == "-" && c == "-") k = slt_pkg::TK_DECR;
      if (p == "|" && c == "|") k = slt_pkg::TK_OROR;
      return k;
   endfunction

   always_comb begin
      logic redo, take, closing, is_op, is_sp, early;
      logic [5:0] late, pk;
      slt_pkg::token_type t;
      state_in = state_ff;
      pend_in = pend_ff;
      prev_in = prev_ff;
      lex_in = lex_ff;
      word_in = word_ff;
      line_in = line_ff;
      col_in = col_ff;
      tok0 = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_NONE, 7'd0);
      tok1 = tok0;
      count = 2'd0;
      line0_out = line_ff;
      col0_out = col_ff;
      line_out = line_ff;
      col_out = col_ff;
      redo = 1'b0;
      take = 1'b0;
      closing = 1'b0;
      early = 1'b0;
      late = slt_pkg::TK_EOF;
      pk = slt_pkg::TK_EOF;
      is_op = 1'b0;
      is_sp = 1'b0;
      t = tok0;
      if (end_of_input) begin
         count = 2'd1;
         case (state_ff)
            slt_pkg::ST_ID: begin t = slt_pkg::keyword(lex_ff, word_ff); count = 2'd2; end
            slt_pkg::ST_LNUM: begin
               t = slt_pkg::mk(slt_pkg::TK_INT, slt_pkg::ERR_NONE, lex_ff); count = 2'd2;
            end
            slt_pkg::ST_DNUM: begin
               t = slt_pkg::mk(slt_pkg::TK_DEC, slt_pkg::ERR_NONE, lex_ff); count = 2'd2;
            end
            slt_pkg::ST_VAR: begin
               t = slt_pkg::mk(slt_pkg::TK_VAR, slt_pkg::ERR_NONE, lex_ff); count = 2'd2;
            end
            slt_pkg::ST_AMP: begin
               t = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_AMP, 7'd0); count = 2'd2;
            end
            slt_pkg::ST_OP: begin t = single_op(pend_ff); count = 2'd2; end
            slt_pkg::ST_STR: begin
               t = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_STR, 7'd0); count = 2'd2;
            end
            slt_pkg::ST_BCOM, slt_pkg::ST_BSTAR: begin
               t = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_BCOM, 7'd0); count = 2'd2;
            end
            default: count = 2'd1;
         endcase
         if (count == 2'd2) tok0 = t;
         state_in = slt_pkg::ST_START;
         pend_in = 8'd0;
         prev_in = 8'd0;
         lex_in = 7'd0;
         word_in = 32'd0;
         line_in = 16'd1;
         col_in = 12'd0;
      end else begin
         case (state_ff)
            slt_pkg::ST_ID:
               if (is_lower(char_code)) take = 1'b1;
               else begin
                  tok0 = slt_pkg::keyword(lex_ff, word_ff); count = 2'd1; redo = 1'b1;
               end
            slt_pkg::ST_LNUM:
               if (is_digit(char_code)) take = 1'b1;
               else if (char_code == ".") begin
                  take = 1'b1; state_in = slt_pkg::ST_DNUM;
               end else begin
                  tok0 = slt_pkg::mk(slt_pkg::TK_INT, slt_pkg::ERR_NONE, lex_ff);
                  count = 2'd1; redo = 1'b1;
               end
            slt_pkg::ST_DNUM:
               if (is_digit(char_code)) take = 1'b1;
               else begin
                  tok0 = slt_pkg::mk(slt_pkg::TK_DEC, slt_pkg::ERR_NONE, lex_ff);
                  count = 2'd1; redo = 1'b1;
               end
            slt_pkg::ST_VAR:
               if (is_lower(char_code) || is_upper(char_code) || is_digit(char_code))
                  take = 1'b1;
               else begin
                  tok0 = slt_pkg::mk(slt_pkg::TK_VAR, slt_pkg::ERR_NONE, lex_ff);
                  count = 2'd1; redo = 1'b1;
               end
            slt_pkg::ST_AMP:
               if (char_code == "&") late = slt_pkg::TK_ANDAND;
               else if (is_lower(char_code)) begin
                  state_in = slt_pkg::ST_VAR; take = 1'b1;
               end else begin
                  tok0 = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_AMP, 7'd0);
                  count = 2'd1; redo = 1'b1;
               end
            slt_pkg::ST_OP:
               if (pend_ff == "/" && char_code == "/") state_in = slt_pkg::ST_LCOM;
               else if (pend_ff == "/" && char_code == "*") state_in = slt_pkg::ST_BCOM;
               else begin
                  late = double_kind(pend_ff, char_code);
                  if (late == slt_pkg::TK_EOF) begin
                     tok0 = single_op(pend_ff); count = 2'd1; redo = 1'b1;
                  end
               end
            slt_pkg::ST_STR: begin
               take = 1'b1;
               closing = (char_code == "\"");
            end
            slt_pkg::ST_LCOM:
               if (char_code == 8'h0a) begin
                  state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
               end
            slt_pkg::ST_BCOM:
               if (char_code == "*") state_in = slt_pkg::ST_BSTAR;
            slt_pkg::ST_BSTAR:
               if (char_code == "/") begin
                  state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
               end else if (char_code != "*") state_in = slt_pkg::ST_BCOM;
            default: redo = 1'b1;
         endcase
         early = (count != 2'd0);

         if (prev_ff == 8'h0a) begin
            if (line_ff != 16'hffff) line_in = line_ff + 16'd1;
            col_in = 12'd0;
         end else begin
            col_in = col_ff;
         end
         if (col_in < 12'(slt_pkg::LineChars - 1)) col_in = col_in + 12'd1;
         prev_in = char_code;
         line_out = line_in;
         col_out = col_in;
         line0_out = early ? line_ff : line_in;
         col0_out = early ? col_ff : col_in;

         if (late != slt_pkg::TK_EOF) begin
            tok0 = slt_pkg::mk(late, slt_pkg::ERR_NONE, 7'd2);
            count = 2'd1;
            state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
         end else if (take) begin
            if (lex_ff >= 7'(slt_pkg::MaxTokenChars)) begin
               tok0 = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_LONG, 7'd0);
               count = 2'd1;
               state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
            end else begin
               lex_in = lex_ff + 7'd1;
               word_in = {word_ff[23:0], char_code};
               if (closing) begin
                  tok0 = slt_pkg::mk(slt_pkg::TK_STR, slt_pkg::ERR_NONE, lex_in);
                  count = 2'd1;
                  state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
               end
            end
         end else if (redo) begin
            state_in = slt_pkg::ST_START; lex_in = 7'd0; word_in = 32'd0;
            is_sp = (char_code == " ") || (char_code >= 8'd9 && char_code <= 8'd13);
            case (char_code)
               "=", "<", ">", "!", "+", "-", "|", "/": is_op = 1'b1;
               default: is_op = 1'b0;
            endcase
            if (is_digit(char_code) || is_lower(char_code)) begin
               state_in = is_digit(char_code) ? slt_pkg::ST_LNUM : slt_pkg::ST_ID;
               lex_in = 7'd1;
               word_in = {24'd0, char_code};
            end else if (char_code == "&") begin
               state_in = slt_pkg::ST_AMP; pend_in = char_code; lex_in = 7'd1;
            end else if (char_code == "\"") begin
               state_in = slt_pkg::ST_STR; lex_in = 7'd1;
            end else if (is_sp) begin
               state_in = slt_pkg::ST_START;
            end else if (is_op) begin
               state_in = slt_pkg::ST_OP; pend_in = char_code;
            end else begin
               case (char_code)
                  "*": pk = slt_pkg::TK_STAR;
                  "(": pk = slt_pkg::TK_LPAR;
                  ")": pk = slt_pkg::TK_RPAR;
                  "{": pk = slt_pkg::TK_LBRACE;
                  "}": pk = slt_pkg::TK_RBRACE;
                  ";": pk = slt_pkg::TK_SEMI;
                  ",": pk = slt_pkg::TK_COMMA;
                  ".": pk = slt_pkg::TK_DOT;
                  default: pk = slt_pkg::TK_EOF;
               endcase
               if (pk != slt_pkg::TK_EOF) t = slt_pkg::mk(pk, slt_pkg::ERR_NONE, 7'd1);
               else t = slt_pkg::mk(slt_pkg::TK_EOF, slt_pkg::ERR_CHAR, 7'd0);
               if (count == 2'd0) tok0 = t;
               else tok1 = t;
               count = count + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slt_pkg::ST_START;
         pend_ff <= 8'd0;
         prev_ff <= 8'd0;
         lex_ff <= 7'd0;
         word_ff <= 32'd0;
         line_ff <= 16'd1;
         col_ff <= 12'd0;
      end else if (step) begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         prev_ff <= prev_in;
         lex_ff <= lex_in;
         word_ff <= word_in;
         line_ff <= line_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

[rtl/small_language_tokenizer_top.sv]
// A request's results are written into the result buffer at the edge that takes it.
// Throughput: one request per cycle while req_stall is low; req_stall rises as the
// four-entry result buffer fills, and a request with two results puts both into it.
// Reset: synchronous, active high; scanner returns to its start state at line 1,
// column 0, and all buffered results are dropped.
`default_nettype none
module small_language_tokenizer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_token_kind,
   output logic [3:0]       rsp_error_code,
   output logic [6:0]       rsp_token_length,
   output logic [15:0]      rsp_line_number,
   output logic [11:0]      rsp_column_number,
   output logic             rsp_last_of_run
);

   typedef struct packed {
      slt_pkg::token_type tok;
      logic [15:0] line;
      logic [11:0] col;
      logic        last;
   } entry_type;

   slt_pkg::token_type tok0, tok1;
   logic [1:0]  count;
   logic [15:0] line0_out, line_out;
   logic [11:0] col0_out, col_out;
   logic        step, pop;
   entry_type   buf_ff [0:3];
   logic [1:0]  rd_ff, wr_ff;
   logic [2:0]  fill_ff, fill_in;
   entry_type   e0, e1;

   assign req_stall = (fill_ff > 3'd2) || (fill_ff == 3'd2 && !pop);
   assign step = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   slt_scan u_scan (
      .clock(clock), .reset(reset), .step(step),
      .char_code(req_char_code), .end_of_input(req_end_of_input),
      .tok0(tok0), .tok1(tok1), .count(count),
      .line0_out(line0_out), .col0_out(col0_out),
      .line_out(line_out), .col_out(col_out)
   );

   always_comb begin
      e0.tok = tok0;
      e0.line = line0_out;
      e0.col = col0_out;
      e0.last = (count == 2'd1);
      e1.tok = tok1;
      e1.line = line_out;
      e1.col = col_out;
      e1.last = 1'b1;
      fill_in = fill_ff - {2'd0, pop} + (step ? {1'b0, count} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 2'd0;
         wr_ff <= 2'd0;
         fill_ff <= 3'd0;
      end else begin
         if (step && count != 2'd0) begin
            buf_ff[wr_ff] <= e0;
            if (count == 2'd2) buf_ff[wr_ff + 2'd1] <= e1;
            wr_ff <= wr_ff + count;
         end
         if (pop) rd_ff <= rd_ff + 2'd1;
         fill_ff <= fill_in;
      end
   end

   assign rsp_valid = (fill_ff != 3'd0);
   assign rsp_token_kind = buf_ff[rd_ff].tok.kind;
   assign rsp_error_code = buf_ff[rd_ff].tok.err;
   assign rsp_token_length = buf_ff[rd_ff].tok.len;
   assign rsp_line_number = buf_ff[rd_ff].line;
   assign rsp_column_number = buf_ff[rd_ff].col;
   assign rsp_last_of_run = buf_ff[rd_ff].last;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import slt_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } request_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  err;
      logic [6:0]  len;
      logic [15:0] line;
      logic [11:0] col;
      logic        last;
   } token_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [3:0]  rsp_error_code;
   logic [6:0]  rsp_token_length;
   logic [15:0] rsp_line_number;
   logic [11:0] rsp_column_number;
   logic        rsp_last_of_run;

   small_language_tokenizer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_code(req_char_code), .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_error_code(rsp_error_code),
      .rsp_token_length(rsp_token_length), .rsp_line_number(rsp_line_number),
      .rsp_column_number(rsp_column_number), .rsp_last_of_run(rsp_last_of_run)
   );

   request_type      pending_chars[$];
   token_result_type expected_tokens[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   bit               receiver_held = 1'b0;
   bit               req_taken = 1'b0;
   bit               sender_paused = 1'b0;
   int               error_count = 0;
   int               token_count = 0;
   int               chars_sent = 0;

   scan_state_type   sc_state;
   logic [7:0]       sc_pending;
   logic [7:0]       sc_previous;
   logic [6:0]       sc_count;
   logic [31:0]      sc_word;
   logic [15:0]      sc_line;
   logic [11:0]      sc_col;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit is_lower(logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic bit is_upper(logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_scanner();
      sc_state = ST_START;
      sc_count = 0;
      sc_word = 0;
   endfunction

   function automatic void reset_scanner();
      clear_scanner();
      sc_pending = 0;
      sc_previous = 0;
      sc_line = 1;
      sc_col = 0;
   endfunction

   function automatic void push_token(logic [5:0] k, logic [3:0] e, logic [6:0] l);
      token_result_type t;
      t.kind = k;
      t.err = e;
      t.len = l;
      t.line = sc_line;
      t.col = sc_col;
      t.last = 1'b0;
      expected_tokens.push_back(t);
   endfunction

   function automatic void finish_word();
      logic [5:0] k;
      k = TK_EOF;
      case (sc_count)
         7'd2: if (sc_word == {16'd0, "if"}) k = 6'd2;
         7'd3: begin
            if (sc_word == {8'd0, "for"}) k = 6'd5;
            if (sc_word == {8'd0, "int"}) k = 6'd8;
            if (sc_word == {8'd0, "dec"}) k = 6'd10;
         end
         7'd4: begin
            if (sc_word == "main") k = 6'd1;
            if (sc_word == "then") k = 6'd3;
            if (sc_word == "else") k = 6'd4;
            if (sc_word == "gets") k = 6'd6;
            if (sc_word == "puts") k = 6'd7;
            if (sc_word == "char") k = 6'd9;
         end
         default: k = TK_EOF;
      endcase
      if (k == TK_EOF) push_token(TK_EOF, ERR_WORD, 0);
      else push_token(k, ERR_NONE, sc_count);
   endfunction

   function automatic void single_op(logic [7:0] p);
      case (p)
         "=": push_token(TK_EQ, ERR_NONE, 1);
         "<": push_token(TK_LT, ERR_NONE, 1);
         ">": push_token(TK_GT, ERR_NONE, 1);
         "+": push_token(TK_PLUS, ERR_NONE, 1);
         "-": push_token(TK_MINUS, ERR_NONE, 1);
         "/": push_token(TK_SLASH, ERR_NONE, 1);
         "!": push_token(TK_EOF, ERR_BANG, 0);
         default: push_token(TK_EOF, ERR_BAR, 0);
      endcase
   endfunction

   function automatic logic [5:0] pair_kind(logic [7:0] p, logic [7:0] c);
      if (c == "=") begin
         if (p == "=") return TK_EQEQ;
         if (p == "<") return TK_LE;
         if (p == ">") return TK_GE;
         if (p == "!") return TK_NE;
      end
      if (p == "+" && c == "+") return TK_INC;
      if (p == "-" && c == "-") return TK_DECR;
      if (p == "|" && c == "|") return TK_OROR;
      return TK_EOF;
   endfunction

   function automatic void begin_token(logic [7:0] c);
      clear_scanner();
      if (is_digit(c) || is_lower(c)) begin
         sc_state = is_digit(c) ? ST_LNUM : ST_ID;
         sc_count = 1;
         sc_word = {24'd0, c};
      end else if (c == "&") begin
         sc_state = ST_AMP;
         sc_pending = c;
         sc_count = 1;
      end else if (c == "\"") begin
         sc_state = ST_STR;
         sc_count = 1;
      end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      end else begin
         case (c)
            "=", "<", ">", "!", "+", "-", "|", "/": begin
               sc_state = ST_OP;
               sc_pending = c;
            end
            "*": push_token(TK_STAR, ERR_NONE, 1);
            "(": push_token(TK_LPAR, ERR_NONE, 1);
            ")": push_token(TK_RPAR, ERR_NONE, 1);
            "{": push_token(TK_LBRACE, ERR_NONE, 1);
            "}": push_token(TK_RBRACE, ERR_NONE, 1);
            ";": push_token(TK_SEMI, ERR_NONE, 1);
            ",": push_token(TK_COMMA, ERR_NONE, 1);
            ".": push_token(TK_DOT, ERR_NONE, 1);
            default: push_token(TK_EOF, ERR_CHAR, 0);
         endcase
      end
   endfunction

   function automatic void predict_tokens(request_type r);
      logic [7:0] c;
      logic [5:0] late;
      bit redo, take, closing;
      int start_size;
      c = r.ch;
      late = TK_EOF;
      redo = 0;
      take = 0;
      closing = 0;
      start_size = expected_tokens.size();
      if (r.eoi) begin
         case (sc_state)
            ST_ID: finish_word();
            ST_LNUM: push_token(TK_INT, ERR_NONE, sc_count);
            ST_DNUM: push_token(TK_DEC, ERR_NONE, sc_count);
            ST_VAR: push_token(TK_VAR, ERR_NONE, sc_count);
            ST_AMP: push_token(TK_EOF, ERR_AMP, 0);
            ST_OP: single_op(sc_pending);
            ST_STR: push_token(TK_EOF, ERR_STR, 0);
            ST_BCOM, ST_BSTAR: push_token(TK_EOF, ERR_BCOM, 0);
            default: ;
         endcase
         push_token(TK_EOF, ERR_NONE, 0);
         reset_scanner();
      end else begin
         case (sc_state)
            ST_ID: if (is_lower(c)) take = 1; else begin finish_word(); redo = 1; end
            ST_LNUM: begin
               if (is_digit(c)) take = 1;
               else if (c == ".") begin
                  take = 1;
                  sc_state = ST_DNUM;
               end else begin
                  push_token(TK_INT, ERR_NONE, sc_count);
                  redo = 1;
               end
            end
            ST_DNUM: if (is_digit(c)) take = 1;
               else begin push_token(TK_DEC, ERR_NONE, sc_count); redo = 1; end
            ST_VAR: if (is_lower(c) || is_upper(c) || is_digit(c)) take = 1;
               else begin push_token(TK_VAR, ERR_NONE, sc_count); redo = 1; end
            ST_AMP: begin
               if (c == "&") late = TK_ANDAND;
               else if (is_lower(c)) begin
                  sc_state = ST_VAR;
                  take = 1;
               end else begin
                  push_token(TK_EOF, ERR_AMP, 0);
                  redo = 1;
               end
            end
            ST_OP: begin
               if (sc_pending == "/" && c == "/") sc_state = ST_LCOM;
               else if (sc_pending == "/" && c == "*") sc_state = ST_BCOM;
               else begin
                  late = pair_kind(sc_pending, c);
                  if (late == TK_EOF) begin
                     single_op(sc_pending);
                     redo = 1;
                  end
               end
            end
            ST_STR: begin
               take = 1;
               closing = (c == "\"");
            end
            ST_LCOM: if (c == "\n") clear_scanner();
            ST_BCOM: if (c == "*") sc_state = ST_BSTAR;
            ST_BSTAR: begin
               if (c == "/") clear_scanner();
               else if (c != "*") sc_state = ST_BCOM;
            end
            default: redo = 1;
         endcase
         if (sc_previous == "\n") begin
            if (sc_line != 16'hFFFF) sc_line++;
            sc_col = 0;
         end
         if (sc_col < LineChars - 1) sc_col++;
         sc_previous = c;
         if (late != TK_EOF) begin
            push_token(late, ERR_NONE, 2);
            clear_scanner();
         end else if (take) begin
            if (sc_count >= MaxTokenChars) begin
               push_token(TK_EOF, ERR_LONG, 0);
               clear_scanner();
            end else begin
               sc_count++;
               sc_word = {sc_word[23:0], c};
               if (closing) begin
                  push_token(TK_STR, ERR_NONE, sc_count);
                  clear_scanner();
               end
            end
         end else if (redo) begin
            begin_token(c);
         end
      end
      if (expected_tokens.size() > start_size)
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_taken) chars_sent <= chars_sent + 1;
         if (!req_valid || req_taken) begin
            if (!sender_paused && pending_chars.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_char_code <= pending_chars[0].ch;
               req_end_of_input <= pending_chars[0].eoi;
               pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= receiver_held || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      token_result_type got, want;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_taken)
            predict_tokens('{ch: req_char_code, eoi: req_end_of_input});
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_token_kind, rsp_error_code, rsp_token_length,
                    rsp_line_number, rsp_column_number, rsp_last_of_run};
            token_count++;
            if (expected_tokens.size() == 0) begin
               $error("unexpected result kind %0d", got.kind);
               error_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (got.kind != want.kind) begin
                  $error("token_kind expected %0d actual %0d", want.kind, got.kind);
                  error_count++;
               end
               if (got.err != want.err) begin
                  $error("error_code expected %0d actual %0d", want.err, got.err);
                  error_count++;
               end
               if (got.len != want.len) begin
                  $error("token_length expected %0d actual %0d", want.len, got.len);
                  error_count++;
               end
               if (got.line != want.line) begin
                  $error("line_number expected %0d actual %0d", want.line, got.line);
                  error_count++;
               end
               if (got.col != want.col) begin
                  $error("column_number expected %0d actual %0d", want.col, got.col);
                  error_count++;
               end
               if (got.last != want.last) begin
                  $error("last_of_run expected %0d actual %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic add_char(logic [7:0] c);
      pending_chars.push_back('{ch: c, eoi: 1'b0});
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic add_eoi();
      pending_chars.push_back('{ch: 8'($urandom), eoi: 1'b1});
   endtask

   task automatic drain();
      wait (pending_chars.size() == 0);
      @(posedge clock);
      while (req_valid || expected_tokens.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_random_fragment();
      string words[10] = '{"main", "if", "then", "else", "for", "gets", "puts",
                           "int", "char", "dec"};
      string ops[22] = '{"&&", "==", "=", "<=", "<", ">=", ">", "!=", "++", "+",
                         "--", "-", "||", "*", "/", "(", ")", "{", "}", ";",
                         ",", "."};
      int n;
      case ($urandom_range(11))
         0, 1: add_text(words[$urandom_range(9)]);
         2: begin
            add_char("&");
            add_char(8'("a" + $urandom_range(25)));
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) add_char(8'("A" + $urandom_range(25)));
         end
         3: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_char(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) begin
               add_char(".");
               add_char(8'("0" + $urandom_range(9)));
            end
         end
         4: begin
            add_char("\"");
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) add_char(8'(" " + $urandom_range(90)));
            add_char("\"");
         end
         5, 6: add_text(ops[$urandom_range(21)]);
         7: add_text("// note\n");
         8: add_text("/* a * b */");
         9: add_char($urandom_range(1) ? "\n" : " ");
         10: add_char(8'($urandom));
         default: begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) add_char(8'("a" + $urandom_range(25)));
         end
      endcase
      add_char($urandom_range(2) == 0 ? "\n" : " ");
   endtask

   task automatic run_random(int count);
      int target;
      target = pending_chars.size() + count;
      while (pending_chars.size() < target) begin
         add_random_fragment();
         if ($urandom_range(60) == 0) add_eoi();
      end
      add_eoi();
   endtask

   initial begin
      reset_scanner();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_text("main if then else for gets puts int char dec ");
      add_text("&aZ9 12 3.25 \"s\" && == = <= < >= > != ++ + -- - || * / ");
      add_text("(){};,. ! | &1 foo @ \x80\xff // c\n/* x */ ");
      add_eoi();
      add_text("\"open");
      add_eoi();
      add_text("/* open *");
      add_eoi();
      add_char("&");
      add_eoi();
      add_text("// tail");
      add_eoi();
      for (int i = 0; i < 66; i++) add_char("7");
      add_char("\n");
      add_eoi();
      drain();

      send_idle_pct = 26;
      recv_idle_pct = 49;
      run_random(320);
      fork
         begin
            receiver_held = 1'b1;
            repeat (200) @(posedge clock);
            receiver_held = 1'b0;
         end
      join_none
      drain();

      sender_paused = 1'b1;
      repeat (30) @(posedge clock);
      sender_paused = 1'b0;

      send_idle_pct = 49;
      recv_idle_pct = 26;
      run_random(320);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(320);
      drain();

      $display("testbench: %0d characters sent, %0d tokens checked", chars_sent, token_count);
      $display("testbench: keywords, operators, comments, errors and end marks covered");
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("testbench: done, errors");
      $finish;
   end
endmodule
